FILE: hdl/bphrd_pkg.sv
// ----------------------------------------------------------------------------
// bphrd_pkg
// Types, codes and reset values shared by the button debouncer files.
// ----------------------------------------------------------------------------
package bphrd_pkg;

	localparam int BPH_BUTTON_COUNT = 8;

	localparam int ID_W    = 3;
	localparam int STAMP_W = 32;
	localparam int TIME_W  = 16;
	localparam int MASK_W  = 4;
	localparam int CFG_IDX_W = 3;

	// operation codes
	localparam logic OP_SAMPLE       = 1'b0;
	localparam logic OP_SET_INTERVAL = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_DEBOUNCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD             = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DEBOUNCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_MASK       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INTERVAL = 3'd4;

	// event mask bit positions
	localparam int MASK_PRESS    = 0;
	localparam int MASK_HOLD     = 1;
	localparam int MASK_REPEAT   = 2;
	localparam int MASK_RELEASED = 3;

	// register reset values
	localparam logic [TIME_W-1:0] RST_PRESS_DEBOUNCE   = 16'd50;
	localparam logic [TIME_W-1:0] RST_HOLD             = 16'd1000;
	localparam logic [TIME_W-1:0] RST_RELEASE_DEBOUNCE = 16'd50;
	localparam logic [MASK_W-1:0] RST_EVENT_MASK       = 4'd0;
	localparam logic [TIME_W-1:0] RST_DEFAULT_INTERVAL = 16'd200;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PRESSED  = 3'd1,
		PH_HOLD     = 3'd2,
		PH_REPEAT   = 3'd3,
		PH_RELEASED = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_PRESS       = 3'd1,
		EV_HOLD        = 3'd2,
		EV_REPEAT      = 3'd3,
		EV_PRESS_DONE  = 3'd4,
		EV_REPEAT_DONE = 3'd5,
		EV_RELEASED    = 3'd6
	} event_t;

	typedef struct packed {
		logic               operation;
		logic [ID_W-1:0]    button_id;
		logic               level_active;
		logic [STAMP_W-1:0] now_ms;
		logic [TIME_W-1:0]  new_interval;
	} in_item_t;

	typedef struct packed {
		event_t event_kind;
		logic   reported;
		logic   pressed_now;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] press_debounce_ms;
		logic [TIME_W-1:0] hold_ms;
		logic [TIME_W-1:0] release_debounce_ms;
		logic [MASK_W-1:0] event_mask;
	} cfg_t;

	// per-button entry of the state memory
	typedef struct packed {
		phase_t             phase;
		logic               latch;
		logic [STAMP_W-1:0] stamp;
	} btn_entry_t;

	localparam btn_entry_t ENTRY_RESET = '{phase: PH_IDLE, latch: 1'b0, stamp: '0};

	typedef struct packed {
		btn_entry_t        entry;
		logic [TIME_W-1:0] interval;
	} btn_view_t;

	typedef struct packed {
		logic              we_entry;
		btn_entry_t        entry;
		logic              we_interval;
		logic [TIME_W-1:0] interval;
	} btn_upd_t;

endpackage

FILE: hdl/bphrd_store.sv
// ----------------------------------------------------------------------------
// bphrd_store
// Per-button state memory and repeat interval memory, read on acceptance
// with forwarding of the write made in the same cycle.
// ----------------------------------------------------------------------------
module bphrd_store
	import bphrd_pkg::*;
#(
	parameter int BUTTON_COUNT = BPH_BUTTON_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ID_W-1:0]   rd_id,
	input  logic [ID_W-1:0]   cur_id,
	input  logic              wr_en,
	input  btn_upd_t          upd,
	input  logic              interval_clear,
	input  logic [TIME_W-1:0] default_interval,
	output btn_view_t         view
);

	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	btn_entry_t        entry_mem [BUTTON_COUNT];
	logic [TIME_W-1:0] interval_mem [BUTTON_COUNT];

	logic [BUTTON_COUNT-1:0] entry_vld_q;
	logic [BUTTON_COUNT-1:0] interval_vld_q;

	btn_entry_t        rd_entry_s1;
	logic [TIME_W-1:0] rd_interval_s1;

	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] cur_idx;
	logic             wr_entry;
	logic             wr_interval;
	logic             fwd;

	// out-of-range ids never write, so a safe index suffices for them
	assign rd_idx  = (int'(rd_id) < BUTTON_COUNT) ? IDX_W'(rd_id) : '0;
	assign cur_idx = (int'(cur_id) < BUTTON_COUNT) ? IDX_W'(cur_id) : '0;

	assign wr_entry    = wr_en && upd.we_entry;
	assign wr_interval = wr_en && upd.we_interval;
	assign fwd         = (rd_idx == cur_idx);

	always_ff @(posedge clk) begin
		if (wr_entry) begin
			entry_mem[cur_idx] <= upd.entry;
		end
		if (rd_en) begin
			if (wr_entry && fwd) begin
				rd_entry_s1 <= upd.entry;
			end else begin
				rd_entry_s1 <= entry_mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_interval) begin
			interval_mem[cur_idx] <= upd.interval;
		end
		if (rd_en) begin
			if (wr_interval && fwd) begin
				rd_interval_s1 <= upd.interval;
			end else begin
				rd_interval_s1 <= interval_mem[rd_idx];
			end
		end
	end

	// an entry not yet written reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q    <= '0;
			interval_vld_q <= '0;
		end else begin
			if (wr_entry) begin
				entry_vld_q[cur_idx] <= 1'b1;
			end
			if (interval_clear) begin
				interval_vld_q <= '0;
			end else if (wr_interval) begin
				interval_vld_q[cur_idx] <= 1'b1;
			end
		end
	end

	assign view.entry    = entry_vld_q[cur_idx] ? rd_entry_s1 : ENTRY_RESET;
	assign view.interval = interval_vld_q[cur_idx] ? rd_interval_s1 : default_interval;

endmodule

FILE: hdl/bphrd_step.sv
// ----------------------------------------------------------------------------
// bphrd_step
// Next phase, stamp, latch and event for one transaction on one button.
// ----------------------------------------------------------------------------
module bphrd_step
	import bphrd_pkg::*;
(
	input  in_item_t  item,
	input  logic      in_range,
	input  btn_view_t view,
	input  cfg_t      cfg,
	output btn_upd_t  upd,
	output out_item_t res
);

	logic [STAMP_W-1:0] elapsed;
	logic               press_done;
	logic               hold_done;
	logic               repeat_due;
	logic               release_done;

	assign elapsed      = item.now_ms - view.entry.stamp;
	assign press_done   = elapsed > STAMP_W'(cfg.press_debounce_ms);
	assign hold_done    = elapsed > STAMP_W'(cfg.hold_ms);
	assign repeat_due   = elapsed > STAMP_W'(view.interval);
	assign release_done = elapsed > STAMP_W'(cfg.release_debounce_ms);

	always_comb begin
		upd.we_entry    = 1'b0;
		upd.entry       = view.entry;
		upd.we_interval = 1'b0;
		upd.interval    = item.new_interval;
		res.event_kind  = EV_NONE;
		res.reported    = 1'b0;
		res.pressed_now = 1'b0;

		if (in_range) begin
			if (item.operation == OP_SET_INTERVAL) begin
				upd.we_interval = 1'b1;
			end else begin
				upd.we_entry = 1'b1;
				if (item.level_active) begin
					case (view.entry.phase)
						PH_IDLE: begin
							upd.entry.phase = PH_PRESSED;
							upd.entry.stamp = item.now_ms;
							upd.entry.latch = 1'b1;
						end
						PH_PRESSED: begin
							if (press_done) begin
								upd.entry.phase = PH_HOLD;
								upd.entry.stamp = item.now_ms;
								res.event_kind  = EV_PRESS;
								res.reported    = cfg.event_mask[MASK_PRESS];
							end
						end
						PH_HOLD: begin
							if (hold_done) begin
								upd.entry.phase = PH_REPEAT;
								upd.entry.stamp = item.now_ms;
								res.event_kind  = EV_HOLD;
								res.reported    = cfg.event_mask[MASK_HOLD];
							end
						end
						PH_REPEAT: begin
							if (repeat_due) begin
								upd.entry.stamp = item.now_ms;
								res.event_kind  = EV_REPEAT;
								res.reported    = cfg.event_mask[MASK_REPEAT];
							end
						end
						default: begin
						end
					endcase
				end else begin
					case (view.entry.phase)
						PH_PRESSED: begin
							upd.entry.phase = PH_RELEASED;
							upd.entry.stamp = item.now_ms;
						end
						PH_HOLD: begin
							upd.entry.phase = PH_RELEASED;
							upd.entry.stamp = item.now_ms;
							res.event_kind  = EV_PRESS_DONE;
						end
						PH_REPEAT: begin
							upd.entry.phase = PH_RELEASED;
							upd.entry.stamp = item.now_ms;
							res.event_kind  = EV_REPEAT_DONE;
						end
						PH_RELEASED: begin
							if (release_done) begin
								upd.entry.phase = PH_IDLE;
								if (view.entry.latch) begin
									upd.entry.latch = 1'b0;
									res.event_kind  = EV_RELEASED;
									res.reported    = cfg.event_mask[MASK_RELEASED];
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			res.pressed_now = upd.entry.latch;
		end
	end

endmodule

FILE: hdl/button_press_hold_repeat_debouncer.sv
// ----------------------------------------------------------------------------
// button_press_hold_repeat_debouncer
// Debouncer with hold detection and auto-repeat for a bank of buttons.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the receiver takes results.
// On acceptance the request lands in an input register while the addressed
// button's state and repeat interval are read from their memories. Once the
// result register is free, one pass of subtract, compare and phase selection
// fills the result register and writes the state back. While a result waits
// on the receiver, one more transaction can be taken into the input register;
// after that the input stalls until the result is accepted. A write made in
// the same cycle as a read of the same button is forwarded, so consecutive
// transactions on one button see each other's effect. Reset takes effect at
// once through per-button valid bits; there is no clearing pass. Writing the
// default repeat interval returns every button to that interval.
module button_press_hold_repeat_debouncer
	import bphrd_pkg::*;
#(
	parameter int BUTTON_COUNT = BPH_BUTTON_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  in_item_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output out_item_t            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	cfg_t              cfg_q;
	logic [TIME_W-1:0] default_interval_q;

	in_item_t  req_s1;
	logic      vld_s1;
	out_item_t rsp_q;
	logic      rsp_vld_q;

	logic      req_fire;
	logic      s1_fire;
	logic      in_range_s1;
	btn_view_t view;
	btn_upd_t  upd;
	out_item_t res;

	assign s1_fire   = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || s1_fire;
	assign req_fire  = req_valid && req_ready;

	assign in_range_s1 = int'(req_s1.button_id) < BUTTON_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_debounce_ms   <= RST_PRESS_DEBOUNCE;
			cfg_q.hold_ms             <= RST_HOLD;
			cfg_q.release_debounce_ms <= RST_RELEASE_DEBOUNCE;
			cfg_q.event_mask          <= RST_EVENT_MASK;
			default_interval_q        <= RST_DEFAULT_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESS_DEBOUNCE:   cfg_q.press_debounce_ms   <= cfg_data;
				REG_HOLD:             cfg_q.hold_ms             <= cfg_data;
				REG_RELEASE_DEBOUNCE: cfg_q.release_debounce_ms <= cfg_data;
				REG_EVENT_MASK:       cfg_q.event_mask          <= cfg_data[MASK_W-1:0];
				REG_DEFAULT_INTERVAL: default_interval_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req_ready) begin
				vld_s1 <= req_valid;
			end
			if (s1_fire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (s1_fire) begin
			rsp_q <= res;
		end
	end

	bphrd_store #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_store (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_en           (req_fire),
		.rd_id           (req.button_id),
		.cur_id          (req_s1.button_id),
		.wr_en           (s1_fire),
		.upd             (upd),
		.interval_clear  (cfg_we && (cfg_index == REG_DEFAULT_INTERVAL)),
		.default_interval(default_interval_q),
		.view            (view)
	);

	bphrd_step u_step (
		.item    (req_s1),
		.in_range(in_range_s1),
		.view    (view),
		.cfg     (cfg_q),
		.upd     (upd),
		.res     (res)
	);

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

FILE: hdl/bphrd_checker.sv
// ----------------------------------------------------------------------------
// bphrd_checker
// Port-level checks on the result channel of the button debouncer.
// ----------------------------------------------------------------------------
module bphrd_checker
	import bphrd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp
);

	// hold a stalled transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reported |->
			(rsp.event_kind == EV_PRESS || rsp.event_kind == EV_HOLD ||
			 rsp.event_kind == EV_REPEAT || rsp.event_kind == EV_RELEASED))
		else $error("reported flag on an event that is never reported");

	// the latch stays set from press until the release is debounced
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.event_kind == EV_PRESS || rsp.event_kind == EV_HOLD ||
			rsp.event_kind == EV_REPEAT || rsp.event_kind == EV_PRESS_DONE ||
			rsp.event_kind == EV_REPEAT_DONE) |-> rsp.pressed_now)
		else $error("press-side event without pressed flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_kind == EV_RELEASED |-> !rsp.pressed_now)
		else $error("released event with pressed flag still set");

endmodule

bind button_press_hold_repeat_debouncer bphrd_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
